>>> hdl/stok_pkg.sv
// ============================================================================
// stok_pkg: shared types and constants of the source tokenizer
// Token kinds, error causes, character codes, scan modes and token records.
// ============================================================================
package stok_pkg;

    localparam int MAX_NAME_LEN_DEF = 15;
    localparam int LINE_BITS_DEF    = 16;
    localparam int NAME_SLOTS       = 15;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QCW              = $clog2(QUEUE_DEPTH + 1);

    // Token kinds.
    localparam logic [5:0] TK_ERROR       = 6'd0;
    localparam logic [5:0] TK_IDENT       = 6'd1;
    localparam logic [5:0] TK_NUMBER      = 6'd2;
    localparam logic [5:0] TK_COMMENT     = 6'd3;
    localparam logic [5:0] TK_END         = 6'd4;
    localparam logic [5:0] TK_KW_CHAR     = 6'd5;
    localparam logic [5:0] TK_KW_ELSE     = 6'd6;
    localparam logic [5:0] TK_KW_IF       = 6'd7;
    localparam logic [5:0] TK_KW_INT      = 6'd8;
    localparam logic [5:0] TK_KW_MAIN     = 6'd9;
    localparam logic [5:0] TK_KW_READINT  = 6'd10;
    localparam logic [5:0] TK_KW_VOID     = 6'd11;
    localparam logic [5:0] TK_KW_WHILE    = 6'd12;
    localparam logic [5:0] TK_KW_WRITEINT = 6'd13;
    localparam logic [5:0] TK_LPAREN      = 6'd14;
    localparam logic [5:0] TK_RPAREN      = 6'd15;
    localparam logic [5:0] TK_LBRACE      = 6'd16;
    localparam logic [5:0] TK_RBRACE      = 6'd17;
    localparam logic [5:0] TK_COMMA       = 6'd18;
    localparam logic [5:0] TK_SEMI        = 6'd19;
    localparam logic [5:0] TK_ASSIGN      = 6'd20;
    localparam logic [5:0] TK_EQ          = 6'd21;
    localparam logic [5:0] TK_OR          = 6'd22;
    localparam logic [5:0] TK_AND         = 6'd23;
    localparam logic [5:0] TK_LE          = 6'd24;
    localparam logic [5:0] TK_LT          = 6'd25;
    localparam logic [5:0] TK_GE          = 6'd26;
    localparam logic [5:0] TK_GT          = 6'd27;
    localparam logic [5:0] TK_NE          = 6'd28;
    localparam logic [5:0] TK_PLUS        = 6'd29;
    localparam logic [5:0] TK_MINUS       = 6'd30;
    localparam logic [5:0] TK_STAR        = 6'd31;
    localparam logic [5:0] TK_SLASH       = 6'd32;
    localparam logic [5:0] TK_HEX         = 6'd33;
    localparam logic [5:0] TK_CHARCODE    = 6'd34;

    // Error causes.
    localparam logic [2:0] EC_NONE      = 3'd0;
    localparam logic [2:0] EC_BAD_CHAR  = 3'd1;
    localparam logic [2:0] EC_LONE_OP   = 3'd2;
    localparam logic [2:0] EC_TOO_LONG  = 3'd3;
    localparam logic [2:0] EC_OPEN_COMM = 3'd4;
    localparam logic [2:0] EC_BAD_CODE  = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keyword spellings, first character in the low byte.
    localparam logic [63:0] KW_CHAR     = 64'h0000_0000_7261_6863;
    localparam logic [63:0] KW_ELSE     = 64'h0000_0000_6573_6C65;
    localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6669;
    localparam logic [63:0] KW_INT      = 64'h0000_0000_0074_6E69;
    localparam logic [63:0] KW_MAIN     = 64'h0000_0000_6E69_616D;
    localparam logic [63:0] KW_READINT  = 64'h0074_6E69_6461_6572;
    localparam logic [63:0] KW_VOID     = 64'h0000_0000_6469_6F76;
    localparam logic [63:0] KW_WHILE    = 64'h0000_0065_6C69_6877;
    localparam logic [63:0] KW_WRITEINT = 64'h746E_6965_7469_7277;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_ZERO, M_HEX, M_CODE,
        M_SLASH, M_LINECOM, M_BLOCK, M_BLOCKSTAR, M_PEND
    } mode_t;

    // One classified source character.
    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
        logic       blank;
        logic       digit;
        logic       alpha;
        logic       hexaf;
        logic       idchar;
    } cls_t;

    // One token record.
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [63:0] value;
        logic [4:0]  places;
        logic [3:0]  len;
        logic [63:0] head;
        logic [55:0] tail;
        logic [2:0]  cause;
        logic        sat;
        logic        last;
    } tok_t;

    function automatic tok_t mk_tok(input logic [5:0] kind, input logic [15:0] line,
                                    input logic [63:0] value, input logic [4:0] places,
                                    input logic [2:0] cause, input logic sat);
        tok_t t;
        t        = '0;
        t.kind   = kind;
        t.line   = line;
        t.value  = value;
        t.places = places;
        t.cause  = cause;
        t.sat    = sat;
        return t;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [63:0] head, input logic [3:0] len);
        logic [5:0] k;
        k = TK_IDENT;
        if (len == 4'd4 && head == KW_CHAR)     k = TK_KW_CHAR;
        if (len == 4'd4 && head == KW_ELSE)     k = TK_KW_ELSE;
        if (len == 4'd2 && head == KW_IF)       k = TK_KW_IF;
        if (len == 4'd3 && head == KW_INT)      k = TK_KW_INT;
        if (len == 4'd4 && head == KW_MAIN)     k = TK_KW_MAIN;
        if (len == 4'd7 && head == KW_READINT)  k = TK_KW_READINT;
        if (len == 4'd4 && head == KW_VOID)     k = TK_KW_VOID;
        if (len == 4'd5 && head == KW_WHILE)    k = TK_KW_WHILE;
        if (len == 4'd8 && head == KW_WRITEINT) k = TK_KW_WRITEINT;
        return k;
    endfunction

endpackage

>>> hdl/stok_fifo.sv
// ============================================================================
// stok_fifo: small register queue
// Up to two entries written per cycle, one read per cycle from the head.
// ============================================================================
module stok_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push0,
    input  logic                         push1,
    input  logic [WIDTH-1:0]             din0,
    input  logic [WIDTH-1:0]             din1,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic                         not_empty,
    output logic [$clog2(DEPTH+1)-1:0]   free
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next, wp1, wp2;
    logic [CW-1:0]    count_reg, count_next;

    assign wp1 = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign wp2 = (wp1 == AW'(DEPTH - 1)) ? '0 : wp1 + 1'b1;

    always_comb begin
        wptr_next = push1 ? wp2 : (push0 ? wp1 : wptr_reg);
        rptr_next = rptr_reg;
        if (pop) begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push0) + CW'(push1) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem[wptr_reg] <= din0;
        end
        if (push1) begin
            mem[wp1] <= din1;
        end
    end

    assign dout      = mem[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign free      = CW'(DEPTH) - count_reg;

endmodule

>>> hdl/stok_front.sv
// ============================================================================
// stok_front: character intake
// Classifies each accepted character and queues it for the scanner.
// ============================================================================
module stok_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_source_byte,
    input  logic           s_end_of_text,
    output logic           cmd_valid,
    output stok_pkg::cls_t cmd_data,
    input  logic           cmd_pop
);
    import stok_pkg::*;

    cls_t          cls;
    logic [QCW-1:0] free;
    logic [$bits(cls_t)-1:0] dout;

    always_comb begin
        cls.eot    = s_end_of_text;
        cls.ch     = s_source_byte;
        cls.blank  = (s_source_byte == CH_SPACE) || (s_source_byte == CH_LF) ||
                     (s_source_byte == CH_CR) || (s_source_byte == CH_TAB);
        cls.digit  = (s_source_byte >= 8'h30) && (s_source_byte <= 8'h39);
        cls.alpha  = ((s_source_byte >= 8'h61) && (s_source_byte <= 8'h7A)) ||
                     ((s_source_byte >= 8'h41) && (s_source_byte <= 8'h5A));
        cls.hexaf  = (s_source_byte >= 8'h41) && (s_source_byte <= 8'h46);
        cls.idchar = cls.alpha || cls.digit || (s_source_byte == CH_UNDER);
    end

    assign s_ready = (free != '0);

    stok_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (s_valid && s_ready),
        .push1     (1'b0),
        .din0      (cls),
        .din1      ('0),
        .pop       (cmd_pop),
        .dout      (dout),
        .not_empty (cmd_valid),
        .free      (free)
    );

    assign cmd_data = cls_t'(dout);

endmodule

>>> hdl/stok_back.sv
// ============================================================================
// stok_back: scanner
// Runs the scan state machine on one queued character per cycle while the
// output queue has room for two tokens, and produces up to two tokens for it.
// ============================================================================
module stok_back #(
    parameter int MAX_NAME_LEN = stok_pkg::MAX_NAME_LEN_DEF,
    parameter int LINE_BITS    = stok_pkg::LINE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    input  stok_pkg::cls_t           cmd_data,
    output logic                     cmd_pop,
    input  logic [stok_pkg::QCW-1:0] out_free,
    output logic                     push0,
    output logic                     push1,
    output stok_pkg::tok_t           tok0,
    output stok_pkg::tok_t           tok1
);
    import stok_pkg::*;

    localparam int NCW = $clog2(MAX_NAME_LEN + 2);
    localparam int IW  = $clog2(MAX_NAME_LEN);

    mode_t                mode_reg, mode_next, start_mode;
    logic [LINE_BITS-1:0] line_reg, line_next, start_reg, start_next;
    logic [63:0]          acc_reg, acc_next;
    logic [4:0]           frac_reg, frac_next;
    logic [1:0]           dot_reg, dot_next;
    logic [7:0]           names_reg [MAX_NAME_LEN];
    logic [7:0]           names_next [MAX_NAME_LEN];
    logic [NCW-1:0]       cnt_reg, cnt_next;
    logic [7:0]           held_reg, held_next;
    logic                 sat_reg, sat_next;

    logic        fire, brk, fv, v0, v1, pend_char, special;
    logic [7:0]  c;
    logic [5:0]  pair_k;
    logic [67:0] mul68;
    logic        ovf;
    logic [3:0]  hexval;
    logic [7:0]  pad [NAME_SLOTS];
    logic [63:0] nm_head;
    logic [55:0] nm_tail;
    tok_t        ft, e0, e1;

    assign fire    = cmd_valid && (out_free >= QCW'(2));
    assign cmd_pop = fire;
    assign c       = cmd_data.ch;

    assign pend_char = (c == CH_EQUAL) || (c == CH_BAR) || (c == CH_AMP) ||
                       (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
    assign special   = (c == CH_QUOTE) || (c == CH_SLASH) || cmd_data.digit ||
                       cmd_data.alpha || (c == CH_UNDER) || pend_char;

    // Decimal step x*10+d; a carry out of 64 bits means saturation.
    assign mul68  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 68'(c[3:0]);
    assign ovf    = |mul68[67:64];
    assign hexval = cmd_data.digit ? c[3:0] : c[3:0] + 4'd9;

    always_comb begin
        pair_k = TK_ERROR;
        if (held_reg == CH_EQUAL && c == CH_EQUAL) pair_k = TK_EQ;
        if (held_reg == CH_BAR   && c == CH_BAR)   pair_k = TK_OR;
        if (held_reg == CH_AMP   && c == CH_AMP)   pair_k = TK_AND;
        if (held_reg == CH_LT    && c == CH_EQUAL) pair_k = TK_LE;
        if (held_reg == CH_GT    && c == CH_EQUAL) pair_k = TK_GE;
        if (held_reg == CH_BANG  && c == CH_EQUAL) pair_k = TK_NE;
    end

    always_comb begin
        start_mode = M_IDLE;
        if (c == CH_QUOTE)                         start_mode = M_CODE;
        else if (c == CH_SLASH)                    start_mode = M_SLASH;
        else if (c == CH_ZERO)                     start_mode = M_ZERO;
        else if (cmd_data.digit)                   start_mode = M_NUMBER;
        else if (cmd_data.alpha || c == CH_UNDER)  start_mode = M_IDENT;
        else if (pend_char)                        start_mode = M_PEND;
    end

    // Next scan mode, and whether the character closes the pending token.
    always_comb begin
        brk       = 1'b0;
        mode_next = mode_reg;
        if (fire) begin
            if (cmd_data.eot) begin
                mode_next = M_IDLE;
            end else begin
                case (mode_reg)
                    M_IDENT: brk = !cmd_data.idchar;
                    M_ZERO: begin
                        if (c == CH_X) mode_next = M_HEX;
                        else if (cmd_data.digit || c == CH_DOT) mode_next = M_NUMBER;
                        else brk = 1'b1;
                    end
                    M_NUMBER: brk = !(cmd_data.digit || c == CH_DOT);
                    M_HEX:    brk = !(cmd_data.digit || cmd_data.hexaf);
                    M_CODE: begin
                        if (c == CH_QUOTE) mode_next = M_IDLE;
                        else if (!cmd_data.digit) brk = 1'b1;
                    end
                    M_SLASH: begin
                        if (c == CH_SLASH) mode_next = M_LINECOM;
                        else if (c == CH_STAR) mode_next = M_BLOCK;
                        else brk = 1'b1;
                    end
                    M_LINECOM: begin
                        if (c == CH_LF) mode_next = M_IDLE;
                    end
                    M_BLOCK: begin
                        if (c == CH_STAR) mode_next = M_BLOCKSTAR;
                    end
                    M_BLOCKSTAR: begin
                        if (c == CH_SLASH) mode_next = M_IDLE;
                        else if (c != CH_STAR) mode_next = M_BLOCK;
                    end
                    M_PEND: begin
                        if (pair_k != TK_ERROR) mode_next = M_IDLE;
                        else brk = 1'b1;
                    end
                    default: brk = 1'b1;
                endcase
                if (brk) mode_next = start_mode;
            end
        end
    end

    // Name fields; characters at or above the count read as zero.
    always_comb begin
        for (int i = 0; i < NAME_SLOTS; i++) pad[i] = 8'h00;
        for (int i = 0; i < MAX_NAME_LEN; i++) begin
            if (NCW'(i) < cnt_reg) pad[i] = names_reg[i];
        end
        for (int i = 0; i < 8; i++) nm_head[8*i +: 8] = pad[i];
        for (int i = 0; i < 7; i++) nm_tail[8*i +: 8] = pad[8+i];
    end

    // Token that the pending scan gives when it is closed.
    always_comb begin
        fv = 1'b1;
        ft = '0;
        case (mode_reg)
            M_IDENT: begin
                if (cnt_reg > NCW'(MAX_NAME_LEN)) begin
                    ft = mk_tok(TK_ERROR, 16'(start_reg), '0, '0, EC_TOO_LONG, 1'b0);
                end else begin
                    ft = mk_tok(kw_kind(nm_head, 4'(cnt_reg)), 16'(start_reg), '0, '0,
                                EC_NONE, 1'b0);
                    ft.len  = 4'(cnt_reg);
                    ft.head = nm_head;
                    ft.tail = nm_tail;
                end
            end
            M_ZERO, M_NUMBER:
                ft = mk_tok(TK_NUMBER, 16'(start_reg), acc_reg, frac_reg, EC_NONE, sat_reg);
            M_HEX:
                ft = mk_tok(TK_HEX, 16'(start_reg), acc_reg, '0, EC_NONE, sat_reg);
            M_CODE:
                ft = mk_tok(TK_ERROR, 16'(start_reg), '0, '0, EC_BAD_CODE, 1'b0);
            M_SLASH:
                ft = mk_tok(TK_SLASH, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
            M_LINECOM:
                ft = mk_tok(TK_COMMENT, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
            M_BLOCK, M_BLOCKSTAR:
                ft = mk_tok(TK_ERROR, 16'(start_reg), '0, '0, EC_OPEN_COMM, 1'b0);
            M_PEND: begin
                if (held_reg == CH_EQUAL)
                    ft = mk_tok(TK_ASSIGN, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
                else if (held_reg == CH_LT)
                    ft = mk_tok(TK_LT, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
                else if (held_reg == CH_GT)
                    ft = mk_tok(TK_GT, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
                else
                    ft = mk_tok(TK_ERROR, 16'(start_reg), '0, '0, EC_LONE_OP, 1'b0);
            end
            default: fv = 1'b0;
        endcase
    end

    // Datapath and emitted tokens.
    always_comb begin
        line_next  = line_reg;
        start_next = start_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        dot_next   = dot_reg;
        names_next = names_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        sat_next   = sat_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        e0 = '0;
        e1 = '0;
        if (fire) begin
            if (cmd_data.eot) begin
                v0 = fv;
                e0 = ft;
                v1 = 1'b1;
                e1 = mk_tok(TK_END, 16'(line_reg), '0, '0, EC_NONE, 1'b0);
                line_next  = LINE_BITS'(1);
                start_next = LINE_BITS'(1);
                acc_next   = '0;
                frac_next  = '0;
                dot_next   = '0;
                cnt_next   = '0;
                held_next  = '0;
                sat_next   = 1'b0;
            end else begin
                if (c == CH_LF && line_reg != {LINE_BITS{1'b1}}) begin
                    line_next = line_reg + 1'b1;
                end
                if (brk) begin
                    v0 = fv;
                    e0 = ft;
                    if (!cmd_data.blank) begin
                        start_next = line_reg;
                        acc_next   = '0;
                        frac_next  = '0;
                        dot_next   = '0;
                        sat_next   = 1'b0;
                        cnt_next   = '0;
                        if (cmd_data.digit && c != CH_ZERO) acc_next = 64'(c[3:0]);
                        if (cmd_data.alpha || c == CH_UNDER) begin
                            names_next[0] = c;
                            cnt_next      = NCW'(1);
                        end
                        if (pend_char) held_next = c;
                        if (!special) begin
                            v1 = 1'b1;
                            case (c)
                                CH_LPAREN: e1 = mk_tok(TK_LPAREN, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_RPAREN: e1 = mk_tok(TK_RPAREN, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_LBRACE: e1 = mk_tok(TK_LBRACE, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_RBRACE: e1 = mk_tok(TK_RBRACE, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_COMMA:  e1 = mk_tok(TK_COMMA, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_SEMI:   e1 = mk_tok(TK_SEMI, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_PLUS:   e1 = mk_tok(TK_PLUS, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_MINUS:  e1 = mk_tok(TK_MINUS, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                CH_STAR:   e1 = mk_tok(TK_STAR, 16'(line_reg), '0, '0,
                                                       EC_NONE, 1'b0);
                                default:   e1 = mk_tok(TK_ERROR, 16'(line_reg), '0, '0,
                                                       EC_BAD_CHAR, 1'b0);
                            endcase
                        end
                    end
                end else begin
                    case (mode_reg)
                        M_IDENT: begin
                            if (cnt_reg < NCW'(MAX_NAME_LEN)) names_next[cnt_reg[IW-1:0]] = c;
                            if (cnt_reg <= NCW'(MAX_NAME_LEN)) cnt_next = cnt_reg + 1'b1;
                        end
                        M_ZERO, M_NUMBER: begin
                            if (mode_reg == M_ZERO && c == CH_X) begin
                                acc_next = '0;
                            end else if (cmd_data.digit) begin
                                if (dot_reg == 2'd1) begin
                                    if (frac_reg >= 5'd19 || ovf) begin
                                        sat_next = 1'b1;
                                    end else begin
                                        acc_next  = mul68[63:0];
                                        frac_next = frac_reg + 1'b1;
                                    end
                                end else if (dot_reg == 2'd0) begin
                                    if (ovf) begin
                                        acc_next = '1;
                                        sat_next = 1'b1;
                                    end else begin
                                        acc_next = mul68[63:0];
                                    end
                                end
                            end else if (dot_reg < 2'd2) begin
                                dot_next = dot_reg + 1'b1;
                            end
                        end
                        M_HEX: begin
                            if (|acc_reg[63:60]) begin
                                acc_next = '1;
                                sat_next = 1'b1;
                            end else begin
                                acc_next = {acc_reg[59:0], hexval};
                            end
                        end
                        M_CODE: begin
                            if (cmd_data.digit) begin
                                if (ovf) begin
                                    acc_next = '1;
                                    sat_next = 1'b1;
                                end else begin
                                    acc_next = mul68[63:0];
                                end
                            end else begin
                                v1 = 1'b1;
                                e1 = mk_tok(TK_CHARCODE, 16'(start_reg), {56'b0, acc_reg[7:0]},
                                            '0, EC_NONE, sat_reg);
                            end
                        end
                        M_LINECOM: begin
                            if (c == CH_LF) begin
                                v1 = 1'b1;
                                e1 = mk_tok(TK_COMMENT, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
                            end
                        end
                        M_BLOCKSTAR: begin
                            if (c == CH_SLASH) begin
                                v1 = 1'b1;
                                e1 = mk_tok(TK_COMMENT, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
                            end
                        end
                        M_PEND: begin
                            v1 = 1'b1;
                            e1 = mk_tok(pair_k, 16'(start_reg), '0, '0, EC_NONE, 1'b0);
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // Pack the step's tokens in order and mark the final one.
    always_comb begin
        push0     = v0 || v1;
        push1     = v0 && v1;
        tok0      = v0 ? e0 : e1;
        tok0.last = !(v0 && v1);
        tok1      = e1;
        tok1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            line_reg  <= LINE_BITS'(1);
            start_reg <= LINE_BITS'(1);
            acc_reg   <= '0;
            frac_reg  <= '0;
            dot_reg   <= '0;
            cnt_reg   <= '0;
            held_reg  <= '0;
            sat_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            dot_reg   <= dot_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        names_reg <= names_next;
    end

endmodule

>>> hdl/source_tokenizer.sv
// ============================================================================
// source_tokenizer: streaming lexer for a small C-like language
// One source character per input transaction, one token per output transaction.
// ============================================================================
// Path: an accepted character is written into the command queue, scanned from
//   its head by the scanner, and its tokens are written into the output queue.
// Throughput: one character per cycle while the output queue has room for two;
//   it has one read port, so two tokens of a character leave in two transactions.
// Reset: aresetn is synchronous and active low; both queues empty and the
//   scanner returns to line one in the idle mode. No clearing pass is needed.
module source_tokenizer #(
    parameter int MAX_NAME_LEN = stok_pkg::MAX_NAME_LEN_DEF,
    parameter int LINE_BITS    = stok_pkg::LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [15:0] m_line_number,
    output logic [63:0] m_token_value,
    output logic [4:0]  m_decimal_places,
    output logic [3:0]  m_name_length,
    output logic [63:0] m_name_head,
    output logic [55:0] m_name_tail,
    output logic [2:0]  m_error_cause,
    output logic        m_value_saturated,
    output logic        m_last_of_run
);
    import stok_pkg::*;

    // The front classifies characters into a short command queue; the
    // scanner drains it whenever the output queue has room for two tokens,
    // so a stall on either side is absorbed by the queues until they fill.
    logic           cmd_valid, cmd_pop;
    cls_t           cmd_data;
    logic [QCW-1:0] out_free;
    logic           bk_push0, bk_push1;
    tok_t           bk_tok0, bk_tok1, head_tok;
    logic [$bits(tok_t)-1:0] head_bits;

    stok_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_byte (s_source_byte),
        .s_end_of_text (s_end_of_text),
        .cmd_valid     (cmd_valid),
        .cmd_data      (cmd_data),
        .cmd_pop       (cmd_pop)
    );

    stok_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .LINE_BITS    (LINE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop),
        .out_free  (out_free),
        .push0     (bk_push0),
        .push1     (bk_push1),
        .tok0      (bk_tok0),
        .tok1      (bk_tok1)
    );

    // Output queue; its head register drives the result channel directly.
    stok_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (bk_push0),
        .push1     (bk_push1),
        .din0      (bk_tok0),
        .din1      (bk_tok1),
        .pop       (m_valid && m_ready),
        .dout      (head_bits),
        .not_empty (m_valid),
        .free      (out_free)
    );

    assign head_tok          = tok_t'(head_bits);
    assign m_token_kind      = head_tok.kind;
    assign m_line_number     = head_tok.line;
    assign m_token_value     = head_tok.value;
    assign m_decimal_places  = head_tok.places;
    assign m_name_length     = head_tok.len;
    assign m_name_head       = head_tok.head;
    assign m_name_tail       = head_tok.tail;
    assign m_error_cause     = head_tok.cause;
    assign m_value_saturated = head_tok.sat;
    assign m_last_of_run     = head_tok.last;

`ifndef SYNTHESIS
    // A second token is only ever written together with a first one.
    a_push_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_push1 |-> bk_push0)
        else $error("second token pushed without first");

    // The scanner only writes when the output queue can take both tokens.
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_push0 |-> (out_free >= QCW'(2)))
        else $error("token pushed into a full output queue");

    // An end-of-text character always produces at least the end token.
    a_end_tok: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd_data.eot) |-> bk_push0)
        else $error("end of text produced no token");
`endif

endmodule
